// ===== hdl/rsenc_pkg.sv =====
// ----------------------------------------------------------------------------
// rsenc_pkg
// Shared types, constants and GF(256) arithmetic for the Reed-Solomon encoder.
// ----------------------------------------------------------------------------
package rsenc_pkg;

  localparam int unsigned BYTE_W          = 8;
  localparam int unsigned ECC_LEN_W       = 5;
  localparam int unsigned MAX_ECC_LEN_DEF = 30;

  localparam logic [ECC_LEN_W-1:0] ECC_LEN_RST = ECC_LEN_W'(15);

  // Low byte of the field polynomial x^8+x^4+x^3+x^2+1.
  localparam logic [BYTE_W-1:0] GF_POLY_LOW = 8'h1D;
  localparam logic [BYTE_W-1:0] GF_ONE      = 8'h01;

  typedef struct packed {
    logic [BYTE_W-1:0] data_byte;
    logic              last_byte;
  } rsenc_in_t;

  typedef struct packed {
    logic [BYTE_W-1:0] ecc_byte;
    logic              ecc_last;
  } rsenc_out_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic init_gen;   // load the degree-zero generator and reset the root
    logic build_step; // multiply the generator by (x - root)
    logic absorb;     // fold one message byte into the remainder
    logic shift_out;  // move the remainder one place towards the head
    logic clear_rem;  // zero the remainder after the final ECC byte
  } rsenc_cmd_t;

  function automatic logic [BYTE_W-1:0] gf_xtime(input logic [BYTE_W-1:0] a);
    gf_xtime = {a[BYTE_W-2:0], 1'b0} ^ (a[BYTE_W-1] ? GF_POLY_LOW : '0);
  endfunction

  function automatic logic [BYTE_W-1:0] gf_mul(input logic [BYTE_W-1:0] a,
                                               input logic [BYTE_W-1:0] b);
    logic [BYTE_W-1:0] acc;
    logic [BYTE_W-1:0] m;
    acc = '0;
    m   = a;
    for (int k = 0; k < BYTE_W; k++) begin
      if (b[k]) acc = acc ^ m;
      m = gf_xtime(m);
    end
    gf_mul = acc;
  endfunction

endpackage

// ===== hdl/reed_solomon_ecc_encoder_top.sv =====
// ----------------------------------------------------------------------------
// reed_solomon_ecc_encoder_top
// Systematic Reed-Solomon ECC encoder over GF(256), polynomial 0x11D.
// ----------------------------------------------------------------------------
// Message bytes enter one per item and may be taken back to back while the
// input is not stalled. The item carrying the last byte is absorbed and is
// followed by n ECC items, head first, one per cycle unless the output stalls,
// where n is the programmed ECC length (0 counts as 1, values above
// MAX_ECC_LEN are clamped). The input stalls while the ECC bytes drain. After
// reset and after every write of the length register, the generator
// polynomial is rebuilt root by root by the parallel coefficient multipliers,
// during which the input is stalled. The remainder cells and the generator
// cells each have one GF multiplier, so every cell is updated at once per byte.
// ----------------------------------------------------------------------------
module reed_solomon_ecc_encoder_top
  import rsenc_pkg::*;
#(
  parameter int unsigned MAX_ECC_LEN = MAX_ECC_LEN_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [ECC_LEN_W-1:0] cfg_wdata_i,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  rsenc_in_t            in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output rsenc_out_t           out_data_o
);

  localparam int unsigned LenW = $clog2(MAX_ECC_LEN + 1);

  rsenc_cmd_t        cmd;
  logic [LenW-1:0]   len;
  logic [BYTE_W-1:0] head;
  logic              ecc_last;

  rsenc_ctrl #(
    .MAX_ECC_LEN(MAX_ECC_LEN)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .in_valid_i (in_valid_i),
    .last_byte_i(in_data_i.last_byte),
    .in_stall_o (in_stall_o),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .ecc_last_o (ecc_last),
    .len_i      (len),
    .cmd_o      (cmd)
  );

  rsenc_dpath #(
    .MAX_ECC_LEN(MAX_ECC_LEN)
  ) u_dpath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .cmd_i      (cmd),
    .data_byte_i(in_data_i.data_byte),
    .len_o      (len),
    .head_o     (head)
  );

  assign out_data_o.ecc_byte = head;
  assign out_data_o.ecc_last = ecc_last;

endmodule

// ===== hdl/rsenc_dpath.sv =====
// ----------------------------------------------------------------------------
// rsenc_dpath
// Length register, generator coefficient cells, remainder cells and the
// parallel GF(256) multipliers that update them.
// ----------------------------------------------------------------------------
module rsenc_dpath
  import rsenc_pkg::*;
#(
  parameter int unsigned MAX_ECC_LEN = MAX_ECC_LEN_DEF,
  localparam int unsigned LenW = $clog2(MAX_ECC_LEN + 1)
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [ECC_LEN_W-1:0] cfg_wdata_i,
  input  rsenc_cmd_t           cmd_i,
  input  logic [BYTE_W-1:0]    data_byte_i,
  output logic [LenW-1:0]      len_o,
  output logic [BYTE_W-1:0]    head_o
);

  localparam int unsigned CmpW = (LenW > ECC_LEN_W) ? LenW : ECC_LEN_W;

  logic [ECC_LEN_W-1:0] ecc_len_q;
  logic [CmpW-1:0]      len_ext;
  logic [CmpW-1:0]      len_sel;

  logic [BYTE_W-1:0] gen_q [MAX_ECC_LEN];
  logic [BYTE_W-1:0] gen_d [MAX_ECC_LEN];
  logic [BYTE_W-1:0] rem_q [MAX_ECC_LEN];
  logic [BYTE_W-1:0] rem_d [MAX_ECC_LEN];
  logic [BYTE_W-1:0] root_q;
  logic [BYTE_W-1:0] root_d;
  logic [BYTE_W-1:0] fb;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ecc_len_q <= ECC_LEN_RST;
    end else if (cfg_we_i) begin
      ecc_len_q <= cfg_wdata_i;
    end
  end

  // A length of zero acts as one, and anything above the cell count is clamped.
  always_comb begin
    len_ext = CmpW'(ecc_len_q);
    if (len_ext == '0) begin
      len_sel = CmpW'(1);
    end else if (len_ext > CmpW'(MAX_ECC_LEN)) begin
      len_sel = CmpW'(MAX_ECC_LEN);
    end else begin
      len_sel = len_ext;
    end
  end

  assign len_o  = len_sel[LenW-1:0];
  assign fb     = data_byte_i ^ rem_q[0];
  assign head_o = rem_q[0];

  assign root_d = cmd_i.init_gen ? GF_ONE : gf_xtime(root_q);

  // Cells at or above the length always hold zero, so the shift and the
  // multiply need no length compare: zero simply flows in from the tail.
  for (genvar j = 0; j < MAX_ECC_LEN; j++) begin : g_cell
    logic [BYTE_W-1:0] gen_up;
    logic [BYTE_W-1:0] rem_up;
    if (j + 1 < MAX_ECC_LEN) begin : g_inner
      assign gen_up = gen_q[j+1];
      assign rem_up = rem_q[j+1];
    end else begin : g_tail
      assign gen_up = '0;
      assign rem_up = '0;
    end

    always_comb begin
      if (cmd_i.init_gen) begin
        gen_d[j] = (LenW'(j + 1) == len_o) ? GF_ONE : '0;
      end else begin
        gen_d[j] = gf_mul(gen_q[j], root_q) ^ gen_up;
      end
    end

    always_comb begin
      priority if (cfg_we_i || cmd_i.clear_rem) begin
        rem_d[j] = '0;
      end else if (cmd_i.absorb) begin
        rem_d[j] = rem_up ^ gf_mul(gen_q[j], fb);
      end else begin
        rem_d[j] = rem_up;
      end
    end

    always_ff @(posedge clk_i) begin
      if (cmd_i.init_gen || cmd_i.build_step) begin
        gen_q[j] <= gen_d[j];
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        rem_q[j] <= '0;
      end else if (cfg_we_i || cmd_i.clear_rem || cmd_i.absorb || cmd_i.shift_out) begin
        rem_q[j] <= rem_d[j];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.init_gen || cmd_i.build_step) begin
      root_q <= root_d;
    end
  end

endmodule

// ===== hdl/rsenc_ctrl.sv =====
// ----------------------------------------------------------------------------
// rsenc_ctrl
// Sequencer for generator build, byte absorption and ECC byte emission.
// ----------------------------------------------------------------------------
module rsenc_ctrl
  import rsenc_pkg::*;
#(
  parameter int unsigned MAX_ECC_LEN = MAX_ECC_LEN_DEF,
  localparam int unsigned LenW = $clog2(MAX_ECC_LEN + 1)
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  logic            in_valid_i,
  input  logic            last_byte_i,
  output logic            in_stall_o,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output logic            ecc_last_o,
  input  logic [LenW-1:0] len_i,
  output rsenc_cmd_t      cmd_o
);

  localparam logic [1:0] ST_INIT  = 2'd0;
  localparam logic [1:0] ST_BUILD = 2'd1;
  localparam logic [1:0] ST_RUN   = 2'd2;
  localparam logic [1:0] ST_EMIT  = 2'd3;

  logic [1:0]      state_q;
  logic [1:0]      state_d;
  logic [LenW-1:0] cnt_q;
  logic [LenW-1:0] cnt_d;
  logic            cnt_at_end;
  logic            in_acc;
  logic            out_acc;

  assign cnt_at_end  = (cnt_q == (len_i - LenW'(1)));
  assign in_stall_o  = (state_q != ST_RUN);
  assign out_valid_o = (state_q == ST_EMIT);
  assign ecc_last_o  = cnt_at_end;
  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_acc     = out_valid_o && !out_stall_i;

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    cmd_o   = '0;
    if (cfg_we_i) begin
      // A new length invalidates the generator; rebuild from scratch.
      state_d = ST_INIT;
    end else begin
      unique case (state_q)
        ST_INIT: begin
          cmd_o.init_gen = 1'b1;
          cnt_d          = '0;
          state_d        = ST_BUILD;
        end
        ST_BUILD: begin
          cmd_o.build_step = 1'b1;
          cnt_d            = cnt_q + LenW'(1);
          if (cnt_at_end) begin
            cnt_d   = '0;
            state_d = ST_RUN;
          end
        end
        ST_RUN: begin
          if (in_acc) begin
            cmd_o.absorb = 1'b1;
            cnt_d        = '0;
            if (last_byte_i) state_d = ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (out_acc) begin
            if (cnt_at_end) begin
              cmd_o.clear_rem = 1'b1;
              cnt_d           = '0;
              state_d         = ST_RUN;
            end else begin
              cmd_o.shift_out = 1'b1;
              cnt_d           = cnt_q + LenW'(1);
            end
          end
        end
        default: begin
          state_d = ST_INIT;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_INIT;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule

// ===== dv/tb_reed_solomon_ecc_encoder_top.sv =====
// ----------------------------------------------------------------------------
// tb_reed_solomon_ecc_encoder_top
// Self-checking bench for the GF(256) Reed-Solomon ECC encoder. Message bytes
// are queued by the stimulus process and offered by a clocked driver; a
// clocked monitor folds every accepted byte into a local copy of the encoder
// state and checks each ECC item against the oldest predicted byte.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_reed_solomon_ecc_encoder_top;
  import rsenc_pkg::*;

  localparam int unsigned MAX_LEN     = MAX_ECC_LEN_DEF;
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned SETTLE      = 4;
  localparam int unsigned NUM_SEGS    = 10;
  localparam int unsigned SEG_ITEMS   = 31;
  localparam logic [BYTE_W-1:0] GF_ALPHA = 8'h02;

  logic                 clk_i       = 1'b0;
  logic                 rst_ni      = 1'b0;
  logic                 cfg_we_i    = 1'b0;
  logic [ECC_LEN_W-1:0] cfg_wdata_i = '0;
  logic                 in_valid_i  = 1'b0;
  logic                 in_stall_o;
  rsenc_in_t            in_data_i   = '0;
  logic                 out_valid_o;
  logic                 out_stall_i = 1'b0;
  rsenc_out_t           out_data_o;

  reed_solomon_ecc_encoder_top #(
    .MAX_ECC_LEN (MAX_LEN)
  ) u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  always #1 clk_i = ~clk_i;

  // Local copy of the encoder state.
  logic [ECC_LEN_W-1:0] len_reg = ECC_LEN_RST;
  logic [BYTE_W-1:0]    rem_cells [MAX_LEN];
  logic [BYTE_W-1:0]    gen_cells [MAX_LEN];
  logic                 gen_valid = 1'b0;

  rsenc_in_t   msg_pending  [$];
  rsenc_out_t  ecc_expected [$];

  int unsigned fail_count   = 0;
  int unsigned cycle_count  = 0;
  int unsigned tx_idle_pct  = 0;
  int unsigned rx_stall_pct = 0;
  int unsigned rx_hold_left = 0;
  logic        rx_hold_req  = 1'b0;
  logic        in_taken     = 1'b0;

  function automatic logic [BYTE_W-1:0] gf_product(input logic [BYTE_W-1:0] a,
                                                   input logic [BYTE_W-1:0] b);
    logic [BYTE_W-1:0] acc;
    acc = '0;
    // Horner form: double the partial product, then add a for each set bit.
    for (int k = BYTE_W - 1; k >= 0; k--) begin
      acc = {acc[BYTE_W-2:0], 1'b0} ^ (acc[BYTE_W-1] ? GF_POLY_LOW : 8'h00);
      if (b[k]) acc = acc ^ a;
    end
    return acc;
  endfunction

  function automatic int unsigned active_len();
    if (len_reg == 0) return 1;
    if (len_reg > MAX_LEN) return MAX_LEN;
    return len_reg;
  endfunction

  function automatic void make_generator(input int unsigned n);
    logic [BYTE_W-1:0] root;
    root = GF_ONE;
    for (int j = 0; j < MAX_LEN; j++) gen_cells[j] = '0;
    gen_cells[n-1] = GF_ONE;
    // Multiply by (x - root) for each successive power of alpha.
    for (int i = 0; i < n; i++) begin
      for (int j = 0; j < n; j++) begin
        gen_cells[j] = gf_product(gen_cells[j], root);
        if (j + 1 < n) gen_cells[j] = gen_cells[j] ^ gen_cells[j+1];
      end
      root = gf_product(root, GF_ALPHA);
    end
    gen_valid = 1'b1;
  endfunction

  function automatic void clear_remainder();
    for (int j = 0; j < MAX_LEN; j++) rem_cells[j] = '0;
  endfunction

  function automatic void encode_byte(input rsenc_in_t item);
    int unsigned       n;
    logic [BYTE_W-1:0] fb;
    rsenc_out_t        res;
    n = active_len();
    if (!gen_valid) make_generator(n);
    fb = item.data_byte ^ rem_cells[0];
    for (int j = 0; j + 1 < n; j++) rem_cells[j] = rem_cells[j+1];
    rem_cells[n-1] = '0;
    for (int j = 0; j < n; j++) rem_cells[j] = rem_cells[j] ^ gf_product(gen_cells[j], fb);
    if (item.last_byte) begin
      for (int j = 0; j < n; j++) begin
        res.ecc_byte = rem_cells[j];
        res.ecc_last = (j == n - 1);
        ecc_expected.push_back(res);
      end
      clear_remainder();
    end
  endfunction

  initial clear_remainder();

  // Monitor: tracks configuration writes, predicts on accepted bytes and
  // checks accepted ECC items.
  always @(posedge clk_i) begin : monitor
    rsenc_out_t want;
    in_taken = 1'b0;
    if (rst_ni) begin
      if (cfg_we_i) begin
        len_reg   = cfg_wdata_i;
        gen_valid = 1'b0;
        clear_remainder();
      end
      if (in_valid_i && !in_stall_o) begin
        in_taken = 1'b1;
        encode_byte(in_data_i);
      end
      if (out_valid_o && !out_stall_i) begin
        if (ecc_expected.size() == 0) begin
          if (fail_count < 10)
            $display("unexpected ECC item: byte %02h last %0b",
                     out_data_o.ecc_byte, out_data_o.ecc_last);
          fail_count++;
        end else begin
          want = ecc_expected.pop_front();
          if (out_data_o.ecc_byte !== want.ecc_byte ||
              out_data_o.ecc_last !== want.ecc_last) begin
            if (fail_count < 10)
              $display("ECC mismatch: expected byte %02h last %0b, got byte %02h last %0b",
                       want.ecc_byte, want.ecc_last,
                       out_data_o.ecc_byte, out_data_o.ecc_last);
            fail_count++;
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb_reed_solomon_ecc_encoder_top NOT OK");
      $finish;
    end
  end

  // Driver: a held item stays until it is taken, then the next one is offered
  // unless the sender chooses to idle.
  always @(negedge clk_i) begin : driver
    logic      nxt_valid;
    rsenc_in_t nxt_data;
    nxt_valid = in_valid_i;
    nxt_data  = in_data_i;
    if (rst_ni && (!in_valid_i || in_taken)) begin
      nxt_valid = 1'b0;
      if (msg_pending.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
        nxt_valid = 1'b1;
        nxt_data  = msg_pending.pop_front();
      end
    end
    in_valid_i <= nxt_valid;
    in_data_i  <= nxt_data;
  end

  // Receiver: random stalls, plus one long hold-off when requested.
  always @(negedge clk_i) begin : receiver
    if (rx_hold_req) begin
      rx_hold_left = HOLD_CYCLES;
      rx_hold_req  = 1'b0;
    end
    if (rx_hold_left != 0) begin
      rx_hold_left--;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < rx_stall_pct);
    end
  end

  task automatic push_byte(input logic [BYTE_W-1:0] d, input logic l);
    msg_pending.push_back(rsenc_in_t'{data_byte: d, last_byte: l});
  endtask

  task automatic queue_message(input int unsigned nbytes, input logic closed);
    for (int i = 0; i < nbytes; i++)
      push_byte(8'($urandom_range(255)), closed && (i == nbytes - 1));
  endtask

  task automatic random_segment(input int unsigned target, input logic leave_open);
    int unsigned got;
    int unsigned n;
    got = 0;
    while (got < target) begin
      n = ($urandom_range(9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
      if (n > target - got) n = target - got;
      queue_message(n, 1'b1);
      got += n;
    end
    // An unterminated message is discarded by the next length write.
    if (leave_open) queue_message($urandom_range(1, 5), 1'b0);
  endtask

  // Waits until every queued byte is taken and every ECC item has arrived,
  // then lets a trailing non-last byte settle.
  task automatic drain();
    @(negedge clk_i);
    while (msg_pending.size() != 0 || in_valid_i || ecc_expected.size() != 0)
      @(negedge clk_i);
    repeat (SETTLE) @(negedge clk_i);
  endtask

  task automatic write_ecc_len(input logic [ECC_LEN_W-1:0] v);
    drain();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic set_idling(input int unsigned tx, input int unsigned rx);
    tx_idle_pct  = tx;
    rx_stall_pct = rx;
  endtask

  logic [ECC_LEN_W-1:0] seg_len [NUM_SEGS] = '{5'd2, 5'd30, 5'd0, 5'd31, 5'd9,
                                                5'd1, 5'd16, 5'd23, 5'd5, 5'd17};

  initial begin : stimulus
    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    set_idling(16, 53);

    // Reset length: all-ones and all-zero single-byte messages, then a short one.
    push_byte(8'hFF, 1'b1);
    push_byte(8'h00, 1'b1);
    push_byte(8'h01, 1'b0);
    push_byte(8'h02, 1'b0);
    push_byte(8'h80, 1'b0);
    push_byte(8'h7F, 1'b1);

    // A length of zero behaves as one.
    write_ecc_len(5'd0);
    push_byte(8'hA5, 1'b0);
    push_byte(8'h5A, 1'b1);

    // A length above the maximum is clamped; the partial message that follows
    // is thrown away by the next write.
    write_ecc_len(5'd31);
    push_byte(8'hFF, 1'b0);
    push_byte(8'hFF, 1'b0);
    push_byte(8'h80, 1'b1);
    push_byte(8'h77, 1'b0);
    push_byte(8'h88, 1'b0);

    write_ecc_len(5'd30);
    push_byte(8'h01, 1'b1);
    push_byte(8'hFE, 1'b0);
    push_byte(8'h55, 1'b1);

    write_ecc_len(5'd1);
    push_byte(8'hC3, 1'b1);

    for (int s = 0; s < NUM_SEGS; s++) begin
      write_ecc_len(seg_len[s]);
      if (s < 3) set_idling(16, 53);
      else if (s < 6) set_idling(53, 16);
      else set_idling(0, 0);
      if (s == 8) begin
        // The sender pauses half way until every ECC item is back.
        random_segment(SEG_ITEMS / 2, 1'b0);
        drain();
        random_segment(SEG_ITEMS - SEG_ITEMS / 2, 1'b0);
      end else begin
        random_segment(SEG_ITEMS, (s == 2) || (s == 5));
      end
      // Hold the output off long enough for the encoder to back up its input.
      if (s == 7) rx_hold_req = 1'b1;
    end

    drain();
    repeat (20) @(negedge clk_i);
    if (fail_count == 0 && ecc_expected.size() == 0) begin
      $display("tb_reed_solomon_ecc_encoder_top OK");
    end else begin
      $display("tb_reed_solomon_ecc_encoder_top NOT OK");
    end
    $finish;
  end

endmodule
